// File: design/sinusoidal_position_add_core_defines.svh
// Assertion macros shared by the sinusoidal position add core.
// Expects signals named clock and reset in the using module's scope.
`ifndef SINUSOIDAL_POSITION_ADD_CORE_DEFINES_SVH
`define SINUSOIDAL_POSITION_ADD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spa assertion failed");
`define SPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spa assertion failed");
`else
`define SPA_ASSERT_IMPL(label, ante, cons)
`define SPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/spa_pkg.sv
// Shared types and constants for the sinusoidal position add core.
// No dependencies.
`default_nettype none

package spa_pkg;

   localparam int D_MODEL_DEF       = 512;
   localparam int MAX_POSITIONS_DEF = 4096;
   localparam int CORDIC_STEPS_DEF  = 16;

   localparam int POS_W   = 12;
   localparam int DIM_W   = 9;
   localparam int DATA_W  = 16;
   localparam int ENTRY_W = 31;
   localparam int ROM_AW  = 8;
   localparam int ROM_DEPTH = 1 << ROM_AW;

   // power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CORDIC_FRAC = 30;
   localparam int OUT_FRAC    = 12;
   localparam int CORDIC_W    = 34;
   localparam int ANGLE_W     = 33;
   localparam int PROD_W      = POS_W + ENTRY_W;
   localparam int QUOT_W      = 11;
   localparam int REM_W       = 34;
   localparam int RED_PRE_SHIFT  = 16;
   localparam int RED_RECIP_FRAC = 48;
   localparam int RED_RECIP_W    = 16;
   localparam int ENC_W = 17;
   localparam int SUM_W = 18;

   localparam longint ONE_Q30      = 64'sd1 <<< CORDIC_FRAC;
   localparam longint LN_10000_Q30 = 64'sd9889527671;

   localparam logic [ANGLE_W-1:0] TWO_PI_Q30        = 33'd6746518852;
   localparam logic [ANGLE_W-1:0] PI_Q30            = 33'd3373259426;
   localparam logic [ANGLE_W-1:0] HALF_PI_Q30       = 33'd1686629713;
   localparam logic [ANGLE_W-1:0] THREE_HALF_PI_Q30 = 33'd5059889139;
   localparam logic [RED_RECIP_W-1:0] TWO_PI_RECIP =
      RED_RECIP_W'((64'd1 << RED_RECIP_FRAC) / 64'd6746518852);
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic [POS_W-1:0]          pos;
      logic [ENTRY_W-1:0]        freq;
      logic                      odd;
      logic                      mode;
      logic signed [DATA_W-1:0]  emb;
   } spa_item_type;

   typedef struct packed {
      logic                      odd;
      logic                      mode;
      logic                      neg;
      logic signed [DATA_W-1:0]  emb;
   } spa_side_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } spa_rot_type;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int j);
      logic signed [CORDIC_W-1:0] a;
      unique case (j)
         0: a = 34'sd843314857;
         1: a = 34'sd497837829;
         2: a = 34'sd263043837;
         3: a = 34'sd133525159;
         4: a = 34'sd67021687;
         5: a = 34'sd33543516;
         6: a = 34'sd16775851;
         7: a = 34'sd8388437;
         8: a = 34'sd4194283;
         9: a = 34'sd2097149;
         default: a = 34'sd1 <<< (CORDIC_FRAC - j);
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// File: design/sinusoidal_position_add_core.sv
// Top level of the sinusoidal position add core: mode register, front end, queue, back end.
// Depends on spa_pkg, spa_front, spa_queue and spa_back.
//
// Usage:
//   A transaction (req_position, req_dim_index, req_embedding_value) is taken at a rising
//   edge with start high and busy low. Each transaction gives exactly one result on
//   rsp_sum_value and rsp_overflow, shown for one cycle with rsp_valid high.
//   The encoding is sin for even indices and cos for odd ones, of position times
//   10000^(-2*floor(i/2)/D_MODEL); the sum with the embedding saturates to Q4.12.
//   csr_wr_en writes csr_wr_data into the mode bit (0: add, 1: encoding only); the mode is
//   sampled with each transaction.
// Timing:
//   From the accepting edge, rsp_valid rises through two front stages with the queue,
//   five angle reduction stages, a quadrant fold register, one register per CORDIC
//   iteration, then rounding and saturation registers.
//   One transaction per clock is sustained; the back end drains the queue every cycle,
//   so busy stays low outside reset.
// Reset:
//   Synchronous reset clears the mode bit and empties the pipeline; busy is high during
//   reset. The receiver cannot stall: results are never held back.
`default_nettype none

module sinusoidal_position_add_core import spa_pkg::*; #(
   parameter int D_MODEL       = D_MODEL_DEF,
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [POS_W-1:0]         req_position,
   input  logic [DIM_W-1:0]         req_dim_index,
   input  logic signed [DATA_W-1:0] req_embedding_value,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sum_value,
   output logic                     rsp_overflow,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);

   logic                output_mode_ff;
   logic                push_valid;
   spa_item_type        push_item;
   logic                pop_valid;
   spa_item_type        pop_item;
   logic [QCNT_W-1:0]   level;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         output_mode_ff <= csr_wr_data;
      end
   end

   spa_front #(
      .D_MODEL       (D_MODEL),
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_position        (req_position),
      .req_dim_index       (req_dim_index),
      .req_embedding_value (req_embedding_value),
      .mode                (output_mode_ff),
      .level               (level),
      .push_valid          (push_valid),
      .push_item           (push_item)
   );

   spa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (level)
   );

   spa_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pop_valid),
      .in_item       (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_sum_value (rsp_sum_value),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

// File: design/spa_front.sv
// Front end: accepts transactions, wraps the position, looks up the inverse frequency.
// Depends on spa_pkg and the assertion macro header.
`default_nettype none
`include "sinusoidal_position_add_core_defines.svh"

module spa_front import spa_pkg::*; #(
   parameter int D_MODEL       = D_MODEL_DEF,
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [POS_W-1:0]         req_position,
   input  logic [DIM_W-1:0]         req_dim_index,
   input  logic signed [DATA_W-1:0] req_embedding_value,
   input  logic                     mode,
   input  logic [QCNT_W-1:0]        level,
   output logic                     push_valid,
   output spa_item_type             push_item
);

   localparam int POS_RECIP_W = 24;
   localparam int QP_W = POS_W + POS_RECIP_W;
   localparam int MP_W = 2 * POS_W;
   localparam bit POS_WRAP = (MAX_POSITIONS < (1 << POS_W));
   localparam logic [POS_RECIP_W-1:0] POS_RECIP =
      POS_RECIP_W'((64'd1 << POS_RECIP_W) / MAX_POSITIONS);
   localparam logic [POS_W-1:0] POS_MOD = POS_W'(MAX_POSITIONS);

   function automatic longint div_small(input longint p, input int n);
      longint q;
      unique case (n)
         1: q = p;
         2: q = p / 2;
         3: q = p / 3;
         4: q = p / 4;
         5: q = p / 5;
         6: q = p / 6;
         7: q = p / 7;
         8: q = p / 8;
         9: q = p / 9;
         10: q = p / 10;
         11: q = p / 11;
         12: q = p / 12;
         default: q = p;
      endcase
      return q;
   endfunction

   // 10000^(-2k/D) via exp(-x/64) series, then squared six times
   function automatic logic [ENTRY_W-1:0] inv_freq(input int unsigned k);
      longint x;
      longint r;
      longint term;
      longint acc;
      longint e;
      x = (longint'(k) * 2 * LN_10000_Q30) / D_MODEL;
      if (x >= 23 * ONE_Q30) begin
         return '0;
      end
      r = x >>> 6;
      term = ONE_Q30;
      acc = ONE_Q30;
      for (int n = 1; n <= 12; n++) begin
         term = div_small((term * r) >>> CORDIC_FRAC, n);
         if (n[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > ONE_Q30) begin
         acc = ONE_Q30;
      end
      e = acc;
      for (int n = 0; n < 6; n++) begin
         e = (e * e + (ONE_Q30 >>> 1)) >>> CORDIC_FRAC;
      end
      return e[ENTRY_W-1:0];
   endfunction

   logic [ENTRY_W-1:0] freq_rom [ROM_DEPTH];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      assign freq_rom[g] = inv_freq(g);
   end

   logic                     valid_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         quot_ff;
   logic [ENTRY_W-1:0]       freq_ff;
   logic                     odd_ff;
   logic                     mode_ff;
   logic signed [DATA_W-1:0] emb_ff;

   logic                     accept;
   logic [QP_W-1:0]          quot_prod;
   logic [MP_W-1:0]          mod_prod;
   logic [POS_W-1:0]         rem_raw;
   logic [POS_W-1:0]         rem_fix;

   assign busy   = reset || ((QCNT_W'(valid_ff) + level) >= QCNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   assign quot_prod = QP_W'(req_position) * QP_W'(POS_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff  <= req_position;
         quot_ff <= quot_prod[QP_W-1:POS_RECIP_W];
         freq_ff <= freq_rom[req_dim_index[DIM_W-1:1]];
         odd_ff  <= req_dim_index[0];
         mode_ff <= mode;
         emb_ff  <= req_embedding_value;
      end
   end

   // quotient estimate is low by at most one
   assign mod_prod = MP_W'(quot_ff) * MP_W'(POS_MOD);
   assign rem_raw  = pos_ff - mod_prod[POS_W-1:0];
   assign rem_fix  = (rem_raw >= POS_MOD) ? (rem_raw - POS_MOD) : rem_raw;

   always_comb begin
      push_valid     = valid_ff;
      push_item.pos  = POS_WRAP ? rem_fix : pos_ff;
      push_item.freq = freq_ff;
      push_item.odd  = odd_ff;
      push_item.mode = mode_ff;
      push_item.emb  = emb_ff;
   end

   `SPA_ASSERT_IMPL(a_pos_wrapped, push_valid, (!POS_WRAP || (push_item.pos < POS_MOD)))

endmodule

`default_nettype wire

// File: design/spa_queue.sv
// Short queue between front and back end; the back end drains one entry per cycle.
// Depends on spa_pkg and the assertion macro header.
`default_nettype none
`include "sinusoidal_position_add_core_defines.svh"

module spa_queue import spa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  spa_item_type        push_item,
   output logic                pop_valid,
   output spa_item_type        pop_item,
   output logic [QCNT_W-1:0]   level
);

   spa_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_comb begin
      unique case ({push_valid, pop_valid})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SPA_ASSERT_IMPL(a_no_overrun, push_valid, ((count_ff != QCNT_W'(QUEUE_DEPTH)) || pop_valid))
   `SPA_ASSERT_NEXT(a_push_seen, (push_valid && (count_ff == '0)), pop_valid)

endmodule

`default_nettype wire

// File: design/spa_back.sv
// Back end: angle product, reduction mod 2*pi, quadrant fold, pipelined CORDIC, add and saturate.
// Depends on spa_pkg and the assertion macro header.
`default_nettype none
`include "sinusoidal_position_add_core_defines.svh"

module spa_back import spa_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  spa_item_type             in_item,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sum_value,
   output logic                     rsp_overflow
);

   localparam int VLD_W  = CORDIC_STEPS + 8;
   localparam int V_ROT0 = 5;
   localparam int V_ENC  = CORDIC_STEPS + 6;
   localparam int V_RSP  = CORDIC_STEPS + 7;
   localparam int RND_SHIFT = CORDIC_FRAC - OUT_FRAC;
   localparam logic signed [CORDIC_W-1:0] RND_BIAS = 34'sd1 <<< (RND_SHIFT - 1);
   localparam logic signed [ENC_W-1:0] ENC_LIMIT = 17'sd4100;
   localparam logic signed [SUM_W-1:0] SAT_MAX = 18'sd32767;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -18'sd32768;

   logic [VLD_W-1:0]           valid_ff;

   spa_item_type               s1_item_ff;
   logic [PROD_W-1:0]          s2_prod_ff;
   logic [PROD_W-1:0]          s3_prod_ff;
   logic [QUOT_W-1:0]          s3_quot_ff;
   logic [REM_W-1:0]           s4_rem_ff;
   logic [ANGLE_W-1:0]         s5_theta_ff;
   spa_side_type               s2_side_ff;
   spa_side_type               s3_side_ff;
   spa_side_type               s4_side_ff;
   spa_side_type               s5_side_ff;
   spa_rot_type                rot_ff [CORDIC_STEPS+1];
   spa_rot_type                rot_in [CORDIC_STEPS];
   spa_side_type               rot_side_ff [CORDIC_STEPS+1];
   logic signed [ENC_W-1:0]    enc_ff;
   spa_side_type               enc_side_ff;
   logic signed [DATA_W-1:0]   sum_ff;
   logic                       ovf_ff;

   logic [PROD_W-1:0]          prod_s1;
   spa_side_type               side_s1;
   logic [PROD_W-1:0]          quot_full;
   logic [PROD_W-1:0]          rem_s3;
   logic [ANGLE_W-1:0]         theta_s4;
   logic [CORDIC_W-1:0]        theta_ext;
   logic signed [CORDIC_W-1:0] z_s5;
   logic                       neg_s5;
   logic signed [CORDIC_W-1:0] v_sel;
   logic signed [CORDIC_W-1:0] v_sgn;
   logic signed [CORDIC_W-1:0] v_rnd;
   logic signed [SUM_W-1:0]    sum_full;
   logic signed [DATA_W-1:0]   sum_sat;
   logic                       ovf_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[VLD_W-2:0], in_valid};
      end
   end

   // position times inverse frequency
   assign prod_s1 = PROD_W'(s1_item_ff.pos) * PROD_W'(s1_item_ff.freq);
   always_comb begin
      side_s1.odd  = s1_item_ff.odd;
      side_s1.mode = s1_item_ff.mode;
      side_s1.neg  = 1'b0;
      side_s1.emb  = s1_item_ff.emb;
   end

   // quotient by 2*pi via reciprocal, low by at most one
   assign quot_full = PROD_W'(s2_prod_ff[PROD_W-1:RED_PRE_SHIFT]) * PROD_W'(TWO_PI_RECIP);
   assign rem_s3    = s3_prod_ff - PROD_W'(s3_quot_ff) * PROD_W'(TWO_PI_Q30);
   assign theta_s4  = (s4_rem_ff >= REM_W'(TWO_PI_Q30)) ?
                      ANGLE_W'(s4_rem_ff - REM_W'(TWO_PI_Q30)) : ANGLE_W'(s4_rem_ff);

   // fold into [-pi/2, pi/2)
   assign theta_ext = CORDIC_W'(s5_theta_ff);
   always_comb begin
      priority if (s5_theta_ff < HALF_PI_Q30) begin
         z_s5   = $signed(theta_ext);
         neg_s5 = 1'b0;
      end else if (s5_theta_ff < THREE_HALF_PI_Q30) begin
         z_s5   = $signed(theta_ext - CORDIC_W'(PI_Q30));
         neg_s5 = 1'b1;
      end else begin
         z_s5   = $signed(theta_ext - CORDIC_W'(TWO_PI_Q30));
         neg_s5 = 1'b0;
      end
   end

   always_comb begin
      for (int j = 0; j < CORDIC_STEPS; j++) begin
         rot_in[j] = rot_ff[j];
         if (!rot_ff[j].z[CORDIC_W-1]) begin
            rot_in[j].x = $signed(rot_ff[j].x) - ($signed(rot_ff[j].y) >>> j);
            rot_in[j].y = $signed(rot_ff[j].y) + ($signed(rot_ff[j].x) >>> j);
            rot_in[j].z = $signed(rot_ff[j].z) - atan_q30(j);
         end else begin
            rot_in[j].x = $signed(rot_ff[j].x) + ($signed(rot_ff[j].y) >>> j);
            rot_in[j].y = $signed(rot_ff[j].y) - ($signed(rot_ff[j].x) >>> j);
            rot_in[j].z = $signed(rot_ff[j].z) + atan_q30(j);
         end
      end
   end

   assign v_sel = rot_side_ff[CORDIC_STEPS].odd ? $signed(rot_ff[CORDIC_STEPS].x)
                                                : $signed(rot_ff[CORDIC_STEPS].y);
   assign v_sgn = rot_side_ff[CORDIC_STEPS].neg ? -v_sel : v_sel;
   assign v_rnd = (v_sgn + RND_BIAS) >>> RND_SHIFT;

   always_comb begin
      if (enc_side_ff.mode) begin
         sum_full = SUM_W'(enc_ff);
      end else begin
         sum_full = SUM_W'($signed(enc_side_ff.emb)) + SUM_W'(enc_ff);
      end
      priority if (sum_full > SAT_MAX) begin
         sum_sat = SAT_MAX[DATA_W-1:0];
         ovf_sat = 1'b1;
      end else if (sum_full < SAT_MIN) begin
         sum_sat = SAT_MIN[DATA_W-1:0];
         ovf_sat = 1'b1;
      end else begin
         sum_sat = sum_full[DATA_W-1:0];
         ovf_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= in_item;
      s2_prod_ff  <= prod_s1;
      s2_side_ff  <= side_s1;
      s3_prod_ff  <= s2_prod_ff;
      s3_quot_ff  <= quot_full[PROD_W-1:PROD_W-QUOT_W];
      s3_side_ff  <= s2_side_ff;
      s4_rem_ff   <= rem_s3[REM_W-1:0];
      s4_side_ff  <= s3_side_ff;
      s5_theta_ff <= theta_s4;
      s5_side_ff  <= s4_side_ff;
      rot_ff[0]   <= '{x: CORDIC_GAIN_Q30, y: '0, z: z_s5};
      rot_side_ff[0] <= '{odd: s5_side_ff.odd, mode: s5_side_ff.mode,
                          neg: neg_s5, emb: s5_side_ff.emb};
      for (int j = 0; j < CORDIC_STEPS; j++) begin
         rot_ff[j+1]      <= rot_in[j];
         rot_side_ff[j+1] <= rot_side_ff[j];
      end
      enc_ff      <= v_rnd[ENC_W-1:0];
      enc_side_ff <= rot_side_ff[CORDIC_STEPS];
      sum_ff      <= sum_sat;
      ovf_ff      <= ovf_sat;
   end

   assign rsp_valid     = valid_ff[V_RSP];
   assign rsp_sum_value = sum_ff;
   assign rsp_overflow  = ovf_ff;

   `SPA_ASSERT_IMPL(a_rot_start, valid_ff[V_ROT0], (rot_ff[0].z < $signed(CORDIC_W'(HALF_PI_Q30))))
   `SPA_ASSERT_IMPL(a_enc_range, valid_ff[V_ENC], ((enc_ff <= ENC_LIMIT) && (enc_ff >= -ENC_LIMIT)))
   `SPA_ASSERT_IMPL(a_sat_value, (rsp_valid && rsp_overflow),
                    ((rsp_sum_value == 16'sh7FFF) || (rsp_sum_value == 16'sh8000)))

endmodule

`default_nettype wire

// File: sim/tb_sinusoidal_position_add_core.sv
// Testbench for sinusoidal_position_add_core: directed table, then random transactions.
// Predicts sin/cos positional encoding plus saturating add in Q4.12; needs spa_pkg.
// Results are checked in order against a queue of expected sums, predicted or typed in.
module tb_sinusoidal_position_add_core;
   import spa_pkg::*;

   localparam int     MODEL_DIM   = 512;
   localparam int     ROT_STEPS   = 16;
   localparam longint ONE_Q30_TB  = 64'sd1 <<< 30;
   localparam longint LN10K_Q30   = 64'sd9889527671;
   localparam longint FULL_TURN   = 64'sd6746518852;
   localparam longint HALF_TURN   = FULL_TURN / 2;
   localparam longint QUARTER_TURN = FULL_TURN / 4;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam logic   MODE_ADD    = 1'b0;
   localparam logic   MODE_ENC    = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [POS_W-1:0]         pos;
      logic [DIM_W-1:0]         dim;
      logic signed [DATA_W-1:0] emb;
      logic                     fixed_exp;
      logic signed [DATA_W-1:0] sum;
      logic                     ovf;
   } stim_row_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sum;
      logic                     ovf;
   } result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [POS_W-1:0]         req_position = '0;
   logic [DIM_W-1:0]         req_dim_index = '0;
   logic signed [DATA_W-1:0] req_embedding_value = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_sum_value;
   logic                     rsp_overflow;
   logic                     csr_wr_en = 1'b0;
   logic                     csr_wr_data = 1'b0;

   // typed-in expectation that travels with the driven transaction
   logic                     drv_fixed = 1'b0;
   result_type               drv_result = '0;

   result_type   expected_sums[$];
   stim_row_type directed_rows[$];
   longint    atan_step[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                33543516, 16775851, 8388437, 4194283, 2097149};
   logic      mode_bit = MODE_ADD;
   logic      drv_mode = MODE_ADD;
   int        fail_count = 0;

   sinusoidal_position_add_core DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_position        (req_position),
      .req_dim_index       (req_dim_index),
      .req_embedding_value (req_embedding_value),
      .rsp_valid           (rsp_valid),
      .rsp_sum_value       (rsp_sum_value),
      .rsp_overflow        (rsp_overflow),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 10000^(-2k/D) in Q30: series for exp(-x/64), then squared six times
   function automatic longint unsigned freq_q30(int unsigned k);
      longint            x;
      longint unsigned   r;
      longint unsigned   term;
      longint unsigned   e;
      longint unsigned   n;
      longint            acc;
      x = (longint'(2 * k) * LN10K_Q30) / MODEL_DIM;
      if (x >= 23 * ONE_Q30_TB) begin
         return 0;
      end
      r = longint'(x >>> 6);
      term = ONE_Q30_TB;
      acc = ONE_Q30_TB;
      for (n = 1; n <= 12; n++) begin
         term = ((term * r) >> 30) / n;
         if (n[0]) begin
            acc -= longint'(term);
         end else begin
            acc += longint'(term);
         end
      end
      if (acc < 0) acc = 0;
      if (acc > ONE_Q30_TB) acc = ONE_Q30_TB;
      e = acc;
      for (n = 0; n < 6; n++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      return e;
   endfunction

   function automatic int pos_encoding(logic [POS_W-1:0] pos, logic [DIM_W-1:0] dim);
      longint unsigned theta;
      longint          a, z, x, y, v, dx, dy, ang;
      logic            neg;
      theta = (longint'(pos) * freq_q30(int'(dim >> 1))) % FULL_TURN;
      a = longint'(theta);
      neg = 1'b0;
      if (a < QUARTER_TURN) begin
         z = a;
      end else if (a < 3 * QUARTER_TURN) begin
         z = a - HALF_TURN;
         neg = 1'b1;
      end else begin
         z = a - FULL_TURN;
      end
      x = GAIN_Q30;
      y = 0;
      for (int j = 0; j < ROT_STEPS; j++) begin
         dx = y >>> j;
         dy = x >>> j;
         ang = (j < 10) ? atan_step[j] : (64'sd1 <<< (30 - j));
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ang;
         end else begin
            x += dx;
            y -= dy;
            z += ang;
         end
      end
      v = dim[0] ? x : y;
      if (neg) v = -v;
      return int'((v + 64'sd131072) >>> 18);
   endfunction

   function automatic result_type predict_sum(logic mode, logic [POS_W-1:0] pos,
                                              logic [DIM_W-1:0] dim,
                                              logic signed [DATA_W-1:0] emb);
      int         enc, s;
      result_type r;
      enc = pos_encoding(pos, dim);
      s = (mode == MODE_ENC) ? enc : int'(emb) + enc;
      r.ovf = 1'b0;
      if (s > 32767) begin
         s = 32767;
         r.ovf = 1'b1;
      end else if (s < -32768) begin
         s = -32768;
         r.ovf = 1'b1;
      end
      r.sum = DATA_W'(s);
      return r;
   endfunction

   always @(posedge clock) begin : result_check
      result_type want;
      if (reset) begin
         mode_bit = MODE_ADD;
         expected_sums.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_sums.size() == 0) begin
               $error("unexpected result: sum_value %0d overflow %0b",
                      rsp_sum_value, rsp_overflow);
               fail_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_sum_value !== want.sum) begin
                  $error("sum_value: expected %0d, got %0d", want.sum, rsp_sum_value);
                  fail_count++;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) mode_bit = csr_wr_data;
         if (start && !busy) begin
            if (drv_fixed) begin
               expected_sums.push_back(drv_result);
            end else begin
               expected_sums.push_back(predict_sum(mode_bit, req_position, req_dim_index,
                                                   req_embedding_value));
            end
         end
      end
   end

   task automatic add_row(logic mode, int pos, int dim, int emb, logic fixed_exp = 1'b0,
                          int sum = 0, logic ovf = 1'b0);
      stim_row_type r;
      r.mode = mode;
      r.pos = POS_W'(pos);
      r.dim = DIM_W'(dim);
      r.emb = DATA_W'(emb);
      r.fixed_exp = fixed_exp;
      r.sum = DATA_W'(sum);
      r.ovf = ovf;
      directed_rows.push_back(r);
   endtask

   // wait for the pipeline to empty, then write the mode bit
   task automatic set_mode(logic m);
      start <= 1'b0;
      @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      drv_mode = m;
   endtask

   task automatic issue(stim_row_type r);
      if (r.mode != drv_mode) set_mode(r.mode);
      start <= 1'b1;
      req_position <= r.pos;
      req_dim_index <= r.dim;
      req_embedding_value <= r.emb;
      drv_fixed <= r.fixed_exp;
      drv_result <= '{sum: r.sum, ovf: r.ovf};
      do @(posedge clock); while (busy);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic stim_row_type random_row(logic mode);
      stim_row_type r;
      r = '0;
      r.mode = mode;
      case ($urandom_range(0, 3))
         0: r.pos = POS_W'($urandom_range(0, 31));
         1: r.pos = POS_W'(4095 - $urandom_range(0, 31));
         default: r.pos = POS_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: r.dim = '0;
         1: r.dim = '1;
         default: r.dim = DIM_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: r.emb = 16'sh7FFF;
         1: r.emb = 16'sh8000;
         2: r.emb = DATA_W'(32767 - $urandom_range(0, 4096));
         3: r.emb = DATA_W'(-32768 + $urandom_range(0, 4096));
         default: r.emb = DATA_W'($urandom);
      endcase
      return r;
   endfunction

   initial begin
      int phase_len[4] = '{190, 120, 130, 90};
      // zero position: cos is exactly one, sin rounds to zero
      add_row(MODE_ADD, 0, 0, 0, 1'b1, 0, 1'b0);
      add_row(MODE_ADD, 0, 1, 0, 1'b1, 4096, 1'b0);
      add_row(MODE_ADD, 0, 1, 32767, 1'b1, 32767, 1'b1);
      add_row(MODE_ADD, 0, 0, -32768, 1'b1, -32768, 1'b0);
      add_row(MODE_ADD, 0, 0, 32767, 1'b1, 32767, 1'b0);
      add_row(MODE_ADD, 0, 1, -32768, 1'b1, -28672, 1'b0);
      add_row(MODE_ADD, 4095, 511, 32767);
      add_row(MODE_ADD, 4095, 510, -32768);
      add_row(MODE_ADD, 2, 0, 32767);
      add_row(MODE_ADD, 3, 1, -32768);
      add_row(MODE_ADD, 1, 0, 0);
      add_row(MODE_ADD, 2048, 255, 21845);
      add_row(MODE_ADD, 1365, 256, -21846);
      add_row(MODE_ADD, 4095, 0, 0);
      add_row(MODE_ENC, 0, 1, -32768, 1'b1, 4096, 1'b0);
      add_row(MODE_ENC, 0, 0, 32767, 1'b1, 0, 1'b0);
      add_row(MODE_ENC, 4095, 511, 32767);
      add_row(MODE_ENC, 3, 1, -32768);
      add_row(MODE_ENC, 2730, 170, 12345);
      add_row(MODE_ENC, 100, 1, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         maybe_idle();
         issue(directed_rows[i]);
      end
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < phase_len[p]; i++) begin
            // first stretch of the first phase runs back to back
            if (p != 0 || i >= 80) maybe_idle();
            issue(random_row(p[0] ? MODE_ENC : MODE_ADD));
         end
      end
      start <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS sinusoidal_position_add_core");
      end else begin
         $display("FAIL sinusoidal_position_add_core");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL sinusoidal_position_add_core");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/spa_pkg.sv
design/spa_front.sv
design/spa_queue.sv
design/spa_back.sv
design/sinusoidal_position_add_core.sv
sim/tb_sinusoidal_position_add_core.sv
